// File: sv/bvpm_pkg.sv
// Package with shared constants and codes for the bounded vertical point match.
`timescale 1ns / 1ps
package bvpm_pkg;
  localparam int MAX_CORNERS_DEF = 256;
  localparam int MAX_SURFACE_DEF = 64;
  localparam int COORD_BITS_DEF = 12;
  localparam int KIND_BITS = 3;
  localparam int STATUS_BITS = 3;
  localparam int OFFSET_BITS = 13;
  localparam int RADIUS_BITS = 8;
  localparam int WINDOW_BITS = 12;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [KIND_BITS-1:0] KIND_CLEAR = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_CORNER = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_UPPER = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_LOWER = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_QUERY = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_STORED = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_MERGED = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FOUND = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NONE = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] REG_MERGE_RADIUS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLUMN_WINDOW = 1'd1;
endpackage

// File: sv/bvpm_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
`timescale 1ns / 1ps
interface bvpm_in_if #(parameter int COORD_BITS = 12);
  logic valid;
  logic ready;
  logic [2:0] kind;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  modport source(output valid, kind, pos_x, pos_y, input ready);
  modport sink(input valid, kind, pos_x, pos_y, output ready);
endinterface

interface bvpm_out_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic signed [12:0] offset_y;
  modport source(output valid, status, offset_y, input ready);
  modport sink(input valid, status, offset_y, output ready);
endinterface

interface bvpm_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [11:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: sv/bounded_vertical_point_match.sv
// Top level of the bounded vertical point match with its stores and sequencer.
// One item is handled at a time. Clear, surface adds and unknown kinds go from dispatch
// straight to the output state. A corner add walks the corner store one entry per cycle
// through a shared squared-distance unit. A query walks the upper store, then the lower
// store, then the corner store, one entry per cycle through the same unit.
// A finished result moves into an output register, so the next word is taken while it waits;
// a result that finds that register still occupied holds the input until it is free.
// No clearing pass.
`timescale 1ns / 1ps
module bounded_vertical_point_match
  import bvpm_pkg::*;
#(
  parameter int MAX_CORNERS = MAX_CORNERS_DEF,
  parameter int MAX_SURFACE = MAX_SURFACE_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  bvpm_in_if.sink in_ch,
  bvpm_out_if.source out_ch,
  bvpm_cfg_if.sink cfg_ch
);
  localparam int CA = $clog2(MAX_CORNERS);
  localparam int SA = $clog2(MAX_SURFACE) > 0 ? $clog2(MAX_SURFACE) : 1;
  localparam int CC = $clog2(MAX_CORNERS + 1);
  localparam int SC = $clog2(MAX_SURFACE + 1);
  localparam int CB = COORD_BITS;
  localparam int DB = 2 * CB + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CRD, S_CCHK, S_URD, S_LRD, S_QRD, S_QEND, S_OUT
  } state_t;

  logic [2 * CB - 1:0] corner_mem [MAX_CORNERS];
  logic [2 * CB - 1:0] upper_mem [MAX_SURFACE];
  logic [2 * CB - 1:0] lower_mem [MAX_SURFACE];

  state_t state_r;
  logic [RADIUS_BITS-1:0] radius_r;
  logic [WINDOW_BITS-1:0] window_r;
  logic [CC-1:0] ccount_r;
  logic [SC-1:0] ucount_r, lcount_r;
  logic [2:0] kind_r;
  logic [CB-1:0] qx_r, qy_r;
  logic [CC-1:0] idx_r;
  logic rd_valid_r;
  logic [1:0] rd_src_r;
  logic [2 * CB - 1:0] crd_r, urd_r, lrd_r;
  logic dup_r, have_r;
  logic [DB-1:0] best_d_r;
  logic [CB-1:0] top_r, bot_r, best_y_r, best_dy_r;
  logic [2:0] status_r;
  logic signed [12:0] offset_r;
  logic [2 * RADIUS_BITS - 1:0] r2_r;
  logic out_valid_r;
  logic [2:0] out_status_r;
  logic signed [12:0] out_offset_r;

  logic [2 * CB - 1:0] pt;
  logic [CB-1:0] px, py, dx, dy;
  logic [DB-1:0] d2;
  logic [2 * CB - 1:0] dx2, dy2;

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.offset_y = out_offset_r;

  always_comb begin
    case (rd_src_r)
      2'd0: pt = crd_r;
      2'd1: pt = urd_r;
      default: pt = lrd_r;
    endcase
    px = pt[2 * CB - 1:CB];
    py = pt[CB-1:0];
    dx = (qx_r > px) ? qx_r - px : px - qx_r;
    dy = (qy_r > py) ? qy_r - py : py - qy_r;
    dx2 = dx * dx;
    dy2 = dy * dy;
    d2 = {1'b0, dx2} + {1'b0, dy2};
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CCHK && !dup_r && !(ccount_r >= CC'(MAX_CORNERS)))
      corner_mem[ccount_r[CA-1:0]] <= {qx_r, qy_r};
    if (state_r == S_DISPATCH && kind_r == KIND_UPPER && ucount_r < SC'(MAX_SURFACE))
      upper_mem[ucount_r[SA-1:0]] <= {qx_r, qy_r};
    if (state_r == S_DISPATCH && kind_r == KIND_LOWER && lcount_r < SC'(MAX_SURFACE))
      lower_mem[lcount_r[SA-1:0]] <= {qx_r, qy_r};
    crd_r <= corner_mem[idx_r[CA-1:0]];
    urd_r <= upper_mem[idx_r[SA-1:0]];
    lrd_r <= lower_mem[idx_r[SA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      radius_r <= RADIUS_BITS'(5);
      window_r <= WINDOW_BITS'(10);
      ccount_r <= '0;
      ucount_r <= '0;
      lcount_r <= '0;
      rd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_MERGE_RADIUS: radius_r <= cfg_ch.data[RADIUS_BITS-1:0];
          REG_COLUMN_WINDOW: window_r <= cfg_ch.data[WINDOW_BITS-1:0];
          default: ;
        endcase
      end
      if (state_r != S_OUT && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            kind_r <= in_ch.kind;
            qx_r <= in_ch.pos_x;
            qy_r <= in_ch.pos_y;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          idx_r <= '0;
          rd_valid_r <= 1'b0;
          dup_r <= 1'b0;
          have_r <= 1'b0;
          r2_r <= radius_r * radius_r;
          status_r <= ST_STORED;
          offset_r <= '0;
          state_r <= S_OUT;
          unique case (kind_r)
            KIND_CLEAR: begin
              ccount_r <= '0;
              ucount_r <= '0;
              lcount_r <= '0;
            end
            KIND_CORNER: state_r <= S_CRD;
            KIND_UPPER: begin
              if (ucount_r < SC'(MAX_SURFACE)) ucount_r <= ucount_r + 1'b1;
              else status_r <= ST_FULL;
            end
            KIND_LOWER: begin
              if (lcount_r < SC'(MAX_SURFACE)) lcount_r <= lcount_r + 1'b1;
              else status_r <= ST_FULL;
            end
            KIND_QUERY: begin
              top_r <= '0;
              bot_r <= '0;
              rd_src_r <= 2'd1;
              state_r <= S_URD;
            end
            default: ;
          endcase
          if (kind_r == KIND_CORNER) rd_src_r <= 2'd0;
        end
        S_CRD: begin
          if (rd_valid_r && d2 < DB'(r2_r)) dup_r <= 1'b1;
          if (idx_r < ccount_r) begin
            idx_r <= idx_r + 1'b1;
            rd_valid_r <= 1'b1;
          end else begin
            rd_valid_r <= 1'b0;
            state_r <= S_CCHK;
          end
        end
        S_CCHK: begin
          if (dup_r) status_r <= ST_MERGED;
          else if (ccount_r >= CC'(MAX_CORNERS)) status_r <= ST_FULL;
          else ccount_r <= ccount_r + 1'b1;
          state_r <= S_OUT;
        end
        S_URD, S_LRD: begin
          if (rd_valid_r && (!have_r || d2 < best_d_r)) begin
            have_r <= 1'b1;
            best_d_r <= d2;
            if (state_r == S_URD) top_r <= py;
            else bot_r <= py;
          end
          if (idx_r < CC'(state_r == S_URD ? ucount_r : lcount_r)) begin
            idx_r <= idx_r + 1'b1;
            rd_valid_r <= 1'b1;
          end else begin
            idx_r <= '0;
            rd_valid_r <= 1'b0;
            have_r <= 1'b0;
            if (state_r == S_URD) begin
              rd_src_r <= 2'd2;
              state_r <= S_LRD;
            end else begin
              rd_src_r <= 2'd0;
              state_r <= S_QRD;
            end
          end
        end
        S_QRD: begin
          if (rd_valid_r && !(dx > CB'(window_r)) && !(top_r > py) && !(bot_r < py)
              && (!have_r || dy < best_dy_r || (dy == best_dy_r && py > best_y_r))) begin
            have_r <= 1'b1;
            best_dy_r <= dy;
            best_y_r <= py;
          end
          if (idx_r < ccount_r) begin
            idx_r <= idx_r + 1'b1;
            rd_valid_r <= 1'b1;
          end else begin
            rd_valid_r <= 1'b0;
            state_r <= S_QEND;
          end
        end
        S_QEND: begin
          if (have_r) begin
            status_r <= ST_FOUND;
            offset_r <= 13'(({1'b0, best_y_r}) - ({1'b0, qy_r}));
          end else begin
            status_r <= ST_NONE;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_status_r <= status_r;
            out_offset_r <= offset_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
